>>> rtl/r2h_pkg.sv
`default_nettype none

package r2h_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned ACC_W      = 2 * CHAN_W;
    localparam int unsigned DIV_STEPS  = CHAN_W;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [CHAN_W-1:0] HUE_STEP   = 8'd43;
    localparam logic [CHAN_W-1:0] BASE_RED   = 8'd0;
    localparam logic [CHAN_W-1:0] BASE_GREEN = 8'd85;
    localparam logic [CHAN_W-1:0] BASE_BLUE  = 8'd171;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic              zero;
        logic              neg;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] spread;
        logic [CHAN_W-1:0] absdiff;
    } front_t;

    typedef struct packed {
        logic              zero;
        logic              neg;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] spread;
        logic [ACC_W-1:0]  sat_acc;
        logic [ACC_W-1:0]  hue_acc;
    } div_stage_t;

    // upper half holds the partial remainder, lower half shifts dividend out and quotient in
    function automatic logic [ACC_W-1:0] div_step(
        input logic [ACC_W-1:0]  acc,
        input logic [CHAN_W-1:0] divisor
    );
        logic [CHAN_W:0]   trial;
        logic [CHAN_W:0]   diff;
        logic [ACC_W-1:0]  result;
        trial = {acc[ACC_W-1:CHAN_W], acc[CHAN_W-1]};
        diff  = trial - {1'b0, divisor};
        if (!diff[CHAN_W])
        begin
            result = {diff[CHAN_W-1:0], acc[CHAN_W-2:0], 1'b1};
        end
        else
        begin
            result = {trial[CHAN_W-1:0], acc[CHAN_W-2:0], 1'b0};
        end
        return result;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rgb_to_hsv_converter.sv
`default_nettype none

// 8-bit RGB to HSV pixel converter.
// Request: drive rgb and pulse start; a request is taken at every rising
// edge where start is high and busy is low. busy stays low, so one pixel
// can be taken in every clock cycle.
// Result: hsv is shown for exactly one cycle with done high; the receiver
// takes it at the edge that ends that cycle and cannot hold it off.
// Pipeline: done and hsv come from the output register at the end of the
// front compare stage, multiply stage, eight divider stages and output
// register. The two divisions (saturation and hue) run side by side as
// eight restoring steps, one quotient bit per stage, which sets the depth.
// Throughput: one pixel per clock, results in request order.
// Reset: rst_n clears all valid bits and done; requests in flight are
// dropped. Data registers are not reset.
module rgb_to_hsv_converter
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output      logic          busy,
    input  wire r2h_pkg::rgb_t rgb,
    output      logic          done,
    output      r2h_pkg::hsv_t hsv
);

    localparam int unsigned W = r2h_pkg::CHAN_W;
    localparam int unsigned N = r2h_pkg::DIV_STEPS;

    logic                front_valid_reg;
    r2h_pkg::front_t     front_reg;
    r2h_pkg::front_t     front_next;

    logic                p_valid_reg [0:N];
    r2h_pkg::div_stage_t p_reg       [0:N];
    r2h_pkg::div_stage_t p_next      [0:N];

    logic                done_reg;
    r2h_pkg::hsv_t       hsv_reg;
    r2h_pkg::hsv_t       hsv_next;

    logic                take;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_comb
    begin
        logic [W-1:0] hi;
        logic [W-1:0] lo;
        logic [W:0]   diff;
        hi = rgb.red;
        if (rgb.green > hi)
        begin
            hi = rgb.green;
        end
        if (rgb.blue > hi)
        begin
            hi = rgb.blue;
        end
        lo = rgb.red;
        if (rgb.green < lo)
        begin
            lo = rgb.green;
        end
        if (rgb.blue < lo)
        begin
            lo = rgb.blue;
        end
        // dominant channel: red, then green, then blue on ties
        if (hi == rgb.red)
        begin
            diff            = {1'b0, rgb.green} - {1'b0, rgb.blue};
            front_next.base = r2h_pkg::BASE_RED;
        end
        else if (hi == rgb.green)
        begin
            diff            = {1'b0, rgb.blue} - {1'b0, rgb.red};
            front_next.base = r2h_pkg::BASE_GREEN;
        end
        else
        begin
            diff            = {1'b0, rgb.red} - {1'b0, rgb.green};
            front_next.base = r2h_pkg::BASE_BLUE;
        end
        front_next.hi      = hi;
        front_next.spread  = hi - lo;
        front_next.zero    = (hi == lo);
        front_next.neg     = diff[W];
        front_next.absdiff = diff[W] ? W'(-diff) : diff[W-1:0];
    end

    always_comb
    begin
        p_next[0].zero    = front_reg.zero;
        p_next[0].neg     = front_reg.neg;
        p_next[0].base    = front_reg.base;
        p_next[0].hi      = front_reg.hi;
        p_next[0].spread  = front_reg.spread;
        p_next[0].sat_acc = (2*W)'(front_reg.spread * r2h_pkg::FULL_SCALE);
        p_next[0].hue_acc = (2*W)'(front_reg.absdiff * r2h_pkg::HUE_STEP);
        for (int k = 1; k <= N; k++)
        begin
            p_next[k]         = p_reg[k-1];
            p_next[k].sat_acc = r2h_pkg::div_step(p_reg[k-1].sat_acc, p_reg[k-1].hi);
            p_next[k].hue_acc = r2h_pkg::div_step(p_reg[k-1].hue_acc, p_reg[k-1].spread);
        end
    end

    always_comb
    begin
        logic [W-1:0] q;
        q = p_reg[N].hue_acc[W-1:0];
        hsv_next.brightness = p_reg[N].hi;
        if (p_reg[N].zero)
        begin
            hsv_next.hue        = '0;
            hsv_next.saturation = '0;
        end
        else
        begin
            hsv_next.hue        = p_reg[N].neg ? p_reg[N].base - q : p_reg[N].base + q;
            hsv_next.saturation = p_reg[N].sat_acc[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            for (int k = 0; k <= N; k++)
            begin
                p_valid_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= take;
            p_valid_reg[0]  <= front_valid_reg;
            for (int k = 1; k <= N; k++)
            begin
                p_valid_reg[k] <= p_valid_reg[k-1];
            end
            done_reg <= p_valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        for (int k = 0; k <= N; k++)
        begin
            p_reg[k] <= p_next[k];
        end
        hsv_reg <= hsv_next;
    end

    assign done = done_reg;
    assign hsv  = hsv_reg;

endmodule

`default_nettype wire
